@@ hw/rtl/ata_pic_pkg.sv @@
// Shared types, codes and constants of the ATA PIO command issuer.
// Used by ata_pic_front, ata_pic_queue, ata_pic_back and the top level.
// Depends on nothing else.
`timescale 1ns / 1ps

package ata_pic_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PRESENT   = 3'd0;
   localparam logic [2:0] CSR_ATAPI     = 3'd1;
   localparam logic [2:0] CSR_LBA_CAP   = 3'd2;
   localparam logic [2:0] CSR_LOCATION  = 3'd3;
   localparam logic [2:0] CSR_SIZE_BASE = 3'd4;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_ABSENT = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;

   // Task-file targets.
   localparam logic [3:0] TGT_COUNT  = 4'd2;
   localparam logic [3:0] TGT_LBA0   = 4'd3;
   localparam logic [3:0] TGT_LBA1   = 4'd4;
   localparam logic [3:0] TGT_LBA2   = 4'd5;
   localparam logic [3:0] TGT_DEVSEL = 4'd6;
   localparam logic [3:0] TGT_CMD    = 4'd7;
   localparam logic [3:0] TGT_CTRL   = 4'd8;

   // Device control values and device select bases.
   localparam logic [7:0] CTRL_NIEN = 8'h02;
   localparam logic [7:0] CTRL_HOB  = 8'h82;
   localparam logic [7:0] SEL_CHS   = 8'hA0;
   localparam logic [7:0] SEL_LBA   = 8'hE0;

   // PIO commands.
   localparam logic [7:0] CMD_READ      = 8'h20;
   localparam logic [7:0] CMD_WRITE     = 8'h30;
   localparam logic [7:0] CMD_READ_EXT  = 8'h24;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

   // Addresses at or above this need the 48-bit command set.
   localparam logic [31:0] LBA48_START = 32'h1000_0000;

   // Division by 63 of a 28-bit address: q = (x * CHS_RECIP) >> CHS_SHIFT,
   // exact for every x below 2^28.
   localparam int          CHS_IN_W   = 28;
   localparam int          CHS_RCP_W  = 29;
   localparam int          CHS_PROD_W = CHS_IN_W + CHS_RCP_W;
   localparam int          CHS_SHIFT  = 34;
   localparam int          CHS_Q_W    = CHS_PROD_W - CHS_SHIFT;
   localparam logic [CHS_RCP_W-1:0] CHS_RECIP = 29'd272696337;

   // Sequencer step numbers of the write sequence.
   localparam int          STEP_W       = 5;
   localparam logic [STEP_W-1:0] STEP_SELECT = 5'd1;
   localparam logic [STEP_W-1:0] STEP_COUNT  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_LAST   = 5'd18;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      MODE_CHS,
      MODE_LBA28,
      MODE_LBA48
   } mode_type;

   // One classified request, ready for the back end.
   typedef struct packed {
      logic [1:0] status;
      logic       has_writes;
      logic       lba48;
      logic       channel;
      logic [7:0] select;
      logic [7:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [7:0] command;
   } desc_type;

   // One result word.
   typedef struct packed {
      logic [1:0] status;
      logic       write_valid;
      logic       channel;
      logic [3:0] target;
      logic [7:0] write_data;
      logic       last;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Word emitted for a given step of a request. LBA48 runs steps 0 to 18;
   // the shorter sequences skip from the select step to the count step.
   function automatic word_type build_word(desc_type d, logic [STEP_W-1:0] step);
      word_type w;
      w = '0;
      if (!d.has_writes) begin
         w.status = d.status;
         w.last   = 1'b1;
      end else begin
         w.status      = ST_OK;
         w.write_valid = 1'b1;
         w.channel     = d.channel;
         unique case (step)
            5'd0, 5'd4, 5'd7, 5'd10, 5'd13: begin
               w.target     = TGT_CTRL;
               w.write_data = CTRL_NIEN;
            end
            5'd2, 5'd5, 5'd8, 5'd11: begin
               w.target     = TGT_CTRL;
               w.write_data = CTRL_HOB;
            end
            5'd1: begin
               w.target     = TGT_DEVSEL;
               w.write_data = d.select;
            end
            5'd3: w.target = TGT_COUNT;
            5'd6: begin
               w.target     = TGT_LBA0;
               w.write_data = d.b3;
            end
            5'd9:  w.target = TGT_LBA1;
            5'd12: w.target = TGT_LBA2;
            5'd14: begin
               w.target     = TGT_COUNT;
               w.write_data = d.count;
            end
            5'd15: begin
               w.target     = TGT_LBA0;
               w.write_data = d.b0;
            end
            5'd16: begin
               w.target     = TGT_LBA1;
               w.write_data = d.b1;
            end
            5'd17: begin
               w.target     = TGT_LBA2;
               w.write_data = d.b2;
            end
            5'd18: begin
               w.target     = TGT_CMD;
               w.write_data = d.command;
               w.last       = 1'b1;
            end
            default: w.target = TGT_CTRL;
         endcase
      end
      return w;
   endfunction

endpackage

@@ hw/rtl/ata_pic_front.sv @@
// Front end: configuration registers, request intake and classification.
// Produces one desc_type per request for the queue; uses ata_pic_pkg.
`timescale 1ns / 1ps

module ata_pic_front import ata_pic_pkg::*; #(
   parameter int DRIVE_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_write,
   input  logic [1:0]  req_drive_index,
   input  logic [31:0] req_block_address,
   input  logic [7:0]  req_sector_count,
   output logic        push_valid,
   output desc_type    push_desc,
   input  logic        push_ready
);

   logic [3:0]  present_ff, atapi_ff, lba_cap_ff;
   logic [7:0]  location_ff;
   logic [31:0] size_ff [DRIVE_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         atapi_ff    <= '0;
         lba_cap_ff  <= '0;
         location_ff <= '0;
         for (int i = 0; i < DRIVE_COUNT; i++) size_ff[i] <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_PRESENT)  present_ff  <= csr_wdata[3:0];
         if (csr_index == CSR_ATAPI)    atapi_ff    <= csr_wdata[3:0];
         if (csr_index == CSR_LBA_CAP)  lba_cap_ff  <= csr_wdata[3:0];
         if (csr_index == CSR_LOCATION) location_ff <= csr_wdata[7:0];
         for (int i = 0; i < DRIVE_COUNT; i++) begin
            if (csr_index == CSR_SIZE_BASE + 3'(i)) size_ff[i] <= csr_wdata;
         end
      end
   end

   // Classification of the incoming request.
   logic [31:0] size_sel;
   logic [1:0]  loc_pair;
   logic        drive_ok, beyond;
   logic [1:0]  status_c;
   logic        writes_c;
   mode_type    mode_c;
   logic [CHS_PROD_W-1:0] prod_c;

   always_comb begin
      size_sel = '0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
         if (req_drive_index == 2'(i)) size_sel = size_ff[i];
      end
      drive_ok = ({1'b0, req_drive_index} < 3'(DRIVE_COUNT))
                 && present_ff[req_drive_index];
      beyond   = ({1'b0, req_block_address} + {25'b0, req_sector_count})
                 > {1'b0, size_sel};
      loc_pair = 2'(location_ff >> {req_drive_index, 1'b0});

      if (!drive_ok) begin
         status_c = ST_ABSENT;
         writes_c = 1'b0;
      end else if (atapi_ff[req_drive_index]) begin
         status_c = ST_OK;
         writes_c = 1'b0;
      end else if (beyond) begin
         status_c = ST_RANGE;
         writes_c = 1'b0;
      end else begin
         status_c = ST_OK;
         writes_c = 1'b1;
      end

      if (req_block_address >= LBA48_START) mode_c = MODE_LBA48;
      else if (lba_cap_ff[req_drive_index]) mode_c = MODE_LBA28;
      else                                  mode_c = MODE_CHS;

      prod_c = {{CHS_RCP_W{1'b0}}, req_block_address[CHS_IN_W-1:0]}
               * {{CHS_IN_W{1'b0}}, CHS_RECIP};
   end

   // Stage register after the multiply.
   logic                  a_vld_ff, a_vld_in;
   logic [1:0]            a_status_ff;
   logic                  a_writes_ff, a_ch_ff, a_slave_ff, a_wr_ff;
   mode_type              a_mode_ff;
   logic [7:0]            a_cnt_ff;
   logic [31:0]           a_lba_ff;
   logic [CHS_PROD_W-1:0] a_prod_ff;
   logic                  accept;

   assign req_ready  = !a_vld_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = a_vld_ff;

   always_comb begin
      a_vld_in = a_vld_ff;
      if (accept)          a_vld_in = 1'b1;
      else if (push_ready) a_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= a_vld_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_status_ff <= status_c;
         a_writes_ff <= writes_c;
         a_ch_ff     <= loc_pair[1];
         a_slave_ff  <= loc_pair[0];
         a_wr_ff     <= req_is_write;
         a_mode_ff   <= mode_c;
         a_cnt_ff    <= req_sector_count;
         a_lba_ff    <= req_block_address;
         a_prod_ff   <= prod_c;
      end
   end

   // CHS split: q = lba / 63, cylinder = q / 16, head = q mod 16.
   logic [CHS_Q_W-1:0] q;
   logic [5:0]         q63_low, rem;
   logic [3:0]         head;
   logic [7:0]         base_sel;

   always_comb begin
      q         = a_prod_ff[CHS_PROD_W-1:CHS_SHIFT];
      q63_low   = 6'({q[5:0], 6'b0} - {6'b0, q[5:0]});
      rem       = a_lba_ff[5:0] - q63_low;
      push_desc = '0;
      push_desc.status     = a_status_ff;
      push_desc.has_writes = a_writes_ff;
      push_desc.channel    = a_ch_ff;
      push_desc.count      = a_cnt_ff;
      push_desc.lba48      = (a_mode_ff == MODE_LBA48);
      head     = '0;
      base_sel = SEL_LBA;
      unique case (a_mode_ff)
         MODE_LBA48: begin
            push_desc.b0 = a_lba_ff[7:0];
            push_desc.b1 = a_lba_ff[15:8];
            push_desc.b2 = a_lba_ff[23:16];
            push_desc.b3 = a_lba_ff[31:24];
         end
         MODE_LBA28: begin
            push_desc.b0 = a_lba_ff[7:0];
            push_desc.b1 = a_lba_ff[15:8];
            push_desc.b2 = a_lba_ff[23:16];
            head         = a_lba_ff[27:24];
         end
         default: begin
            push_desc.b0 = {2'b0, rem} + 8'd1;
            push_desc.b1 = q[11:4];
            push_desc.b2 = q[19:12];
            head         = q[3:0];
            base_sel     = SEL_CHS;
         end
      endcase
      push_desc.select = base_sel | {3'b0, a_slave_ff, 4'b0} | {4'b0, head};
      if (a_mode_ff == MODE_LBA48)
         push_desc.command = a_wr_ff ? CMD_WRITE_EXT : CMD_READ_EXT;
      else
         push_desc.command = a_wr_ff ? CMD_WRITE : CMD_READ;
   end

endmodule

@@ hw/rtl/ata_pic_queue.sv @@
// Short descriptor queue that decouples the front end from the sequencer.
// Holds QUEUE_DEPTH entries of desc_type; uses ata_pic_pkg.
`timescale 1ns / 1ps

module ata_pic_queue import ata_pic_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  desc_type  push_desc,
   input  logic      pop,
   output desc_type  head_desc,
   output qstat_type stat
);

   desc_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign stat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push_valid && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

@@ hw/rtl/ata_pic_back.sv @@
// Back end: steps through the task-file write sequence of the head
// descriptor and holds the result word register; uses ata_pic_pkg.
`timescale 1ns / 1ps

module ata_pic_back import ata_pic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  desc_type   head_desc,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic       rsp_write_valid,
   output logic       rsp_channel,
   output logic [3:0] rsp_target,
   output logic [7:0] rsp_write_data,
   output logic       rsp_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   word_type          word_ff, word_c;
   logic              load;

   assign load   = head_valid && (!valid_ff || rsp_ready);
   assign word_c = build_word(head_desc, step_ff);
   assign pop    = load && word_c.last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         if (word_c.last)
            step_in = '0;
         else if (step_ff == STEP_SELECT && !head_desc.lba48)
            step_in = STEP_COUNT;
         else
            step_in = step_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) word_ff <= word_c;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = word_ff.status;
   assign rsp_write_valid = word_ff.write_valid;
   assign rsp_channel     = word_ff.channel;
   assign rsp_target      = word_ff.target;
   assign rsp_write_data  = word_ff.write_data;
   assign rsp_last        = word_ff.last;

endmodule

@@ hw/rtl/ata_pio_command_issuer.sv @@
// Top level of the ATA PIO command issuer: front end, queue and sequencer.
// Depends on ata_pic_pkg, ata_pic_front, ata_pic_queue and ata_pic_back.
//
//   Channel  Direction  Handshake             Words
//   req_*    in         req_valid/req_ready   one read or write request
//   rsp_*    out        rsp_valid/rsp_ready   one task-file write or status
//   csr_*    in         csr_we                one configuration register
//
// An accepted LBA48 request yields 19 result words, an LBA28 or CHS request
// 7, and a rejected or ATAPI request a single word, one word per cycle from
// the sequencer's output register while rsp_ready is high. A request passes
// the stage behind the divide-by-63 multiply before it enters the queue, and
// the sequencer goes on to the next queued request without a gap. Reset is
// synchronous and clears configuration, queue and sequencer. A stalled
// rsp_ready holds the current word; the front keeps accepting until its
// stage and the four-entry queue are full.
`timescale 1ns / 1ps

module ata_pio_command_issuer import ata_pic_pkg::*; #(
   parameter int DRIVE_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_write,
   input  logic [1:0]  req_drive_index,
   input  logic [31:0] req_block_address,
   input  logic [7:0]  req_sector_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_write_valid,
   output logic        rsp_channel,
   output logic [3:0]  rsp_target,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_last
);

   logic      push_valid, pop;
   desc_type  push_desc, head_desc;
   qstat_type q_stat;

   // The front end classifies and converts the address; the queue lets it
   // run ahead while the sequencer is still emitting a long LBA48 sequence.
   ata_pic_front #(
      .DRIVE_COUNT(DRIVE_COUNT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_is_write      (req_is_write),
      .req_drive_index   (req_drive_index),
      .req_block_address (req_block_address),
      .req_sector_count  (req_sector_count),
      .push_valid        (push_valid),
      .push_desc         (push_desc),
      .push_ready        (!q_stat.full)
   );

   ata_pic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_desc  (head_desc),
      .stat       (q_stat)
   );

   // The sequencer pops a descriptor only with its final word.
   ata_pic_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (!q_stat.empty),
      .head_desc       (head_desc),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_write_valid (rsp_write_valid),
      .rsp_channel     (rsp_channel),
      .rsp_target      (rsp_target),
      .rsp_write_data  (rsp_write_data),
      .rsp_last        (rsp_last)
   );

   // A word that is not the last of its request is always followed at once
   // by the next word of the same request, since its descriptor stays queued.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("sequence broke off before its last word");

   // Rejections and ATAPI answers are single words; writes carry status OK.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_valid |-> rsp_status == ST_OK)
      else $error("register write carries a failure status");

   // The queue can never be full and empty at once.
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue occupancy inconsistent");

   // A request the front stage could not hand on keeps the input stalled.
   assert property (@(posedge clock) disable iff (reset)
      push_valid && q_stat.full |-> !req_ready)
      else $error("front accepted a request with nowhere to put it");

endmodule
